// ===== design/csf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package csf_pkg;

  // fixed field widths of the stream payload
  localparam int LAG_W  = 16;
  localparam int CORR_W = 16;
  localparam int K_W    = 16;

  // quotient bits kept by the divider, enough to cover the saturation limit
  localparam int QB = 17;

  // slice width of the pipelined product multiplier
  localparam int MUL_CW = 16;

  // largest value the fraction output may take for a given fraction width
  function automatic int csf_top_value(input int f);
    int v;
    v = (f >= K_W) ? ((1 << K_W) - 1) : (1 << f);
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== design/csf_prep.sv =====
`timescale 1ns / 1ps
`default_nettype none

module csf_prep import csf_pkg::*; #(
  parameter int F = 15
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     en,
  input  wire logic                     valid_i,
  input  wire logic [LAG_W-1:0]         lag_i,
  input  wire logic signed [CORR_W-1:0] mcorr_i,
  input  wire logic signed [CORR_W-1:0] rcorr_i,
  input  wire logic                     last_i,
  output logic                          valid_o,
  output logic [LAG_W-1:0]              lag_o,
  output logic                          last_o,
  output logic                          flag_o,
  output logic                          gt_o,
  output logic [F+1:0]                  num_o,
  output logic [2*F+1:0]                a_o,
  output logic [2*F:0]                  p_o,
  output logic [2*F:0]                  q_o
);

  localparam int RW = F + 2;
  localparam int EW = (RW > CORR_W + 1) ? RW : CORR_W + 1;
  localparam logic signed [EW-1:0] ONE_E = EW'(1) << F;
  localparam logic signed [EW-1:0] NEG_ONE_E = -ONE_E;
  localparam logic signed [2*RW-1:0] ONE2 = (2*RW)'(1) << (2*F);

  logic signed [EW-1:0] m_ext, s_ext;
  logic signed [RW-1:0] r_sat, s_sat;
  logic                 sat_flag;

  logic                 v0_r, v1_r;
  logic [LAG_W-1:0]     lag0_r, lag1_r;
  logic                 last0_r, last1_r, flag0_r, flag1_r, gt1_r;
  logic signed [RW-1:0] r0_r, s0_r;
  logic [F+1:0]         num1_r;
  logic [2*F+1:0]       a1_r;
  logic [2*F:0]         p1_r, q1_r;

  logic signed [2*RW-1:0] rs, rr, ss, a_full, p_full, q_full;
  logic signed [RW:0]     diff;

  // saturate both correlations to plus or minus one
  assign m_ext = EW'(mcorr_i);
  assign s_ext = EW'(rcorr_i);

  always_comb begin
    sat_flag = 1'b0;
    if (m_ext > ONE_E) begin
      r_sat = RW'(ONE_E);
      sat_flag = 1'b1;
    end else if (m_ext < NEG_ONE_E) begin
      r_sat = RW'(NEG_ONE_E);
      sat_flag = 1'b1;
    end else begin
      r_sat = RW'(m_ext);
    end
    if (s_ext > ONE_E) begin
      s_sat = RW'(ONE_E);
      sat_flag = 1'b1;
    end else if (s_ext < NEG_ONE_E) begin
      s_sat = RW'(NEG_ONE_E);
      sat_flag = 1'b1;
    end else begin
      s_sat = RW'(s_ext);
    end
  end

  // products and one-minus terms with doubled fraction bits
  assign rs     = r0_r * s0_r;
  assign rr     = r0_r * r0_r;
  assign ss     = s0_r * s0_r;
  assign a_full = ONE2 - rs;
  assign p_full = ONE2 - rr;
  assign q_full = ONE2 - ss;
  assign diff   = (RW+1)'(r0_r) - (RW+1)'(s0_r);

  // stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else if (en) begin
      v0_r <= valid_i;
      v1_r <= v0_r;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (en) begin
      lag0_r  <= lag_i;
      last0_r <= last_i;
      flag0_r <= sat_flag;
      r0_r    <= r_sat;
      s0_r    <= s_sat;
      lag1_r  <= lag0_r;
      last1_r <= last0_r;
      flag1_r <= flag0_r;
      gt1_r   <= (r0_r > s0_r);
      num1_r  <= diff[F+1:0];
      a1_r    <= a_full[2*F+1:0];
      p1_r    <= p_full[2*F:0];
      q1_r    <= q_full[2*F:0];
    end
  end

  assign valid_o = v1_r;
  assign lag_o   = lag1_r;
  assign last_o  = last1_r;
  assign flag_o  = flag1_r;
  assign gt_o    = gt1_r;
  assign num_o   = num1_r;
  assign a_o     = a1_r;
  assign p_o     = p1_r;
  assign q_o     = q1_r;

endmodule

`default_nettype wire

// ===== design/csf_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none

module csf_mul import csf_pkg::*; #(
  parameter int F   = 15,
  parameter int SBW = 68
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           en,
  input  wire logic           valid_i,
  input  wire logic [2*F:0]   p_i,
  input  wire logic [2*F:0]   q_i,
  input  wire logic [SBW-1:0] sb_i,
  output logic                valid_o,
  output logic [4*F:0]        prod_o,
  output logic [SBW-1:0]      sb_o
);

  localparam int OW = 2 * F + 1;
  localparam int PW = 4 * F + 1;
  localparam int NC = (OW + MUL_CW - 1) / MUL_CW;

  logic           v_r   [NC];
  logic [PW-1:0]  acc_r [NC];
  logic [OW-1:0]  p_r   [NC];
  logic [OW-1:0]  q_r   [NC];
  logic [SBW-1:0] sb_r  [NC];
  logic [PW-1:0]  acc_nxt [NC];
  logic [OW-1:0]  q_nxt   [NC];

  // one slice of q times all of p, added at its weight
  function automatic logic [PW-1:0] mul_slice(input logic [PW-1:0] acc,
                                              input logic [OW-1:0] p,
                                              input logic [OW-1:0] q,
                                              input int j);
    logic [PW-1:0] part;
    part = (PW'(p) * PW'(q[MUL_CW-1:0])) << (j * MUL_CW);
    return acc + part;
  endfunction

  // partial product per stage, q shifted down one slice each time
  always_comb begin
    acc_nxt[0] = mul_slice('0, p_i, q_i, 0);
    q_nxt[0]   = q_i >> MUL_CW;
    for (int j = 1; j < NC; j++) begin
      acc_nxt[j] = mul_slice(acc_r[j-1], p_r[j-1], q_r[j-1], j);
      q_nxt[j]   = q_r[j-1] >> MUL_CW;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < NC; j++) begin
        v_r[j] <= 1'b0;
      end
    end else if (en) begin
      v_r[0] <= valid_i;
      for (int j = 1; j < NC; j++) begin
        v_r[j] <= v_r[j-1];
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      p_r[0]  <= p_i;
      sb_r[0] <= sb_i;
      for (int j = 1; j < NC; j++) begin
        p_r[j]  <= p_r[j-1];
        sb_r[j] <= sb_r[j-1];
      end
      for (int j = 0; j < NC; j++) begin
        acc_r[j] <= acc_nxt[j];
        q_r[j]   <= q_nxt[j];
      end
    end
  end

  assign valid_o = v_r[NC-1];
  assign prod_o  = acc_r[NC-1];
  assign sb_o    = sb_r[NC-1];

endmodule

`default_nettype wire

// ===== design/csf_sqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none

module csf_sqrt import csf_pkg::*; #(
  parameter int F   = 15,
  parameter int SBW = 68
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           en,
  input  wire logic           valid_i,
  input  wire logic [4*F:0]   x_i,
  input  wire logic [SBW-1:0] sb_i,
  output logic                valid_o,
  output logic [2*F:0]        y_o,
  output logic [SBW-1:0]      sb_o
);

  localparam int RMW = 4 * F + 2;
  localparam int YW  = 2 * F + 1;
  localparam int NS  = YW;

  logic           v_r   [NS];
  logic [RMW-1:0] rem_r [NS];
  logic [YW-1:0]  y_r   [NS];
  logic [SBW-1:0] sb_r  [NS];
  logic [RMW+YW-1:0] step_nxt [NS];

  // one root bit: keep it if the remainder covers 2*y*2^b + 4^b
  function automatic logic [RMW+YW-1:0] sqrt_step(input logic [RMW-1:0] rem,
                                                  input logic [YW-1:0] y,
                                                  input int b);
    logic [RMW-1:0] trial;
    logic [RMW-1:0] rem_o;
    logic [YW-1:0]  y_o2;
    trial = (RMW'(y) << (b + 1)) + (RMW'(1) << (2 * b));
    rem_o = rem;
    y_o2  = y;
    if (rem >= trial) begin
      rem_o = rem - trial;
      y_o2  = y | (YW'(1) << b);
    end
    return {rem_o, y_o2};
  endfunction

  // root bits from the top down, one per stage
  always_comb begin
    step_nxt[0] = sqrt_step(RMW'(x_i), '0, NS - 1);
    for (int j = 1; j < NS; j++) begin
      step_nxt[j] = sqrt_step(rem_r[j-1], y_r[j-1], NS - 1 - j);
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < NS; j++) begin
        v_r[j] <= 1'b0;
      end
    end else if (en) begin
      v_r[0] <= valid_i;
      for (int j = 1; j < NS; j++) begin
        v_r[j] <= v_r[j-1];
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      sb_r[0] <= sb_i;
      for (int j = 1; j < NS; j++) begin
        sb_r[j] <= sb_r[j-1];
      end
      for (int j = 0; j < NS; j++) begin
        rem_r[j] <= step_nxt[j][RMW+YW-1:YW];
        y_r[j]   <= step_nxt[j][YW-1:0];
      end
    end
  end

  assign valid_o = v_r[NS-1];
  assign y_o     = y_r[NS-1];
  assign sb_o    = sb_r[NS-1];

endmodule

`default_nettype wire

// ===== design/csf_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module csf_div import csf_pkg::*; #(
  parameter int F = 15
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire logic             valid_i,
  input  wire logic [2*F+1:0]   a_i,
  input  wire logic [2*F:0]     y_i,
  input  wire logic [F+1:0]     num_i,
  input  wire logic             gt_i,
  input  wire logic             flag_i,
  input  wire logic [LAG_W-1:0] lag_i,
  input  wire logic             last_i,
  output logic                  valid_o,
  output logic [LAG_W-1:0]      lag_o,
  output logic [K_W-1:0]        k_o,
  output logic                  flag_o,
  output logic                  last_o
);

  localparam int DENW = 2 * F + 2;
  localparam int DW   = (3 * F + 3 > DENW + QB) ? 3 * F + 3 : DENW + QB;
  localparam int TOP_I   = csf_top_value(F);
  localparam int LIMIT_I = 2 * TOP_I + 1;
  localparam logic [K_W-1:0] TOP   = K_W'(TOP_I);
  localparam logic [QB-1:0]  LIMIT = QB'(LIMIT_I);
  localparam int SW = LAG_W + 4;

  logic [DENW-1:0] den;
  logic [DW-1:0]   dvd;

  // setup stage
  logic            v0_r, over0_r;
  logic [DENW-1:0] den0_r;
  logic [DW-1:0]   rem0_r;
  logic [SW-1:0]   side0_r;

  // quotient stages
  logic            v_r    [QB];
  logic            over_r [QB];
  logic [DENW-1:0] den_r  [QB];
  logic [DW-1:0]   rem_r  [QB];
  logic [QB-1:0]   quo_r  [QB];
  logic [SW-1:0]   side_r [QB];
  logic [DW+QB-1:0] step_nxt [QB];

  // output stage
  logic             vf_r, flagf_r, lastf_r;
  logic [LAG_W-1:0] lagf_r;
  logic [K_W-1:0]   kf_r;
  logic [K_W-1:0]   k_nxt;
  logic             flag_nxt;
  logic [QB:0]      rnd;
  logic             gt_l, flag_l;

  // restoring division bit
  function automatic logic [DW+QB-1:0] div_step(input logic [DW-1:0] rem,
                                                input logic [QB-1:0] quo,
                                                input logic [DENW-1:0] dn,
                                                input int i);
    logic [DW-1:0] dsh;
    logic [DW-1:0] rem_o;
    logic [QB-1:0] quo_o;
    dsh   = DW'(dn) << i;
    rem_o = rem;
    quo_o = quo;
    if (rem >= dsh) begin
      rem_o = rem - dsh;
      quo_o = quo | (QB'(1) << i);
    end
    return {rem_o, quo_o};
  endfunction

  // denominator and early overflow check (a zero denominator lands here too)
  assign den = a_i + DENW'(y_i);
  assign dvd = DW'(num_i) << (2 * F + 1);

  always_comb begin
    step_nxt[0] = div_step(rem0_r, '0, den0_r, QB - 1);
    for (int j = 1; j < QB; j++) begin
      step_nxt[j] = div_step(rem_r[j-1], quo_r[j-1], den_r[j-1], QB - 1 - j);
    end
  end

  // round to nearest and saturate
  assign rnd    = {1'b0, quo_r[QB-1]} + (QB+1)'(1);
  assign gt_l   = side_r[QB-1][1];
  assign flag_l = side_r[QB-1][0];

  always_comb begin
    k_nxt    = '0;
    flag_nxt = flag_l;
    if (gt_l) begin
      if (over_r[QB-1] || (quo_r[QB-1] >= LIMIT)) begin
        k_nxt    = TOP;
        flag_nxt = 1'b1;
      end else begin
        k_nxt = rnd[K_W:1];
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      vf_r <= 1'b0;
      for (int j = 0; j < QB; j++) begin
        v_r[j] <= 1'b0;
      end
    end else if (en) begin
      v0_r   <= valid_i;
      v_r[0] <= v0_r;
      for (int j = 1; j < QB; j++) begin
        v_r[j] <= v_r[j-1];
      end
      vf_r <= v_r[QB-1];
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      den0_r  <= den;
      rem0_r  <= dvd;
      over0_r <= (dvd >= (DW'(den) << QB));
      side0_r <= {lag_i, last_i, 1'b0, gt_i, flag_i};
      den_r[0]  <= den0_r;
      over_r[0] <= over0_r;
      side_r[0] <= side0_r;
      for (int j = 1; j < QB; j++) begin
        den_r[j]  <= den_r[j-1];
        over_r[j] <= over_r[j-1];
        side_r[j] <= side_r[j-1];
      end
      for (int j = 0; j < QB; j++) begin
        rem_r[j] <= step_nxt[j][DW+QB-1:QB];
        quo_r[j] <= step_nxt[j][QB-1:0];
      end
      lagf_r  <= side_r[QB-1][SW-1:4];
      lastf_r <= side_r[QB-1][3];
      kf_r    <= k_nxt;
      flagf_r <= flag_nxt;
    end
  end

  // bit 2 of the side word is unused spare for alignment
  assign valid_o = vf_r;
  assign lag_o   = lagf_r;
  assign k_o     = kf_r;
  assign flag_o  = flagf_r;
  assign last_o  = lastf_r;

endmodule

`default_nettype wire

// ===== design/coherent_scattering_fraction_top.sv =====
// the pipeline depth comes from the bit-per-stage square root and the 17 quotient stages of the divider
// throughput: one point per cycle while the output buffer has room, and every stage takes a new item each cycle
// it advances; a two-entry output buffer holds results while out_tready is low
// reset: synchronous active-low rst_n clears all valid bits and the output buffer's pointers and count
`timescale 1ns / 1ps
`default_nettype none

module coherent_scattering_fraction_top import csf_pkg::*; #(
  parameter int FRAC_BITS = 15
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // lag_position, measured_correlation, rayleigh_correlation
  input  wire logic        in_tlast,   // last_point
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // lag_out, coherent_fraction
  output logic [0:0]       out_tuser,  // clamped
  output logic             out_tlast   // last_out
);

  localparam int F   = FRAC_BITS;
  localparam int SBW = LAG_W + 3 + (F + 2) + (2 * F + 2);
  localparam int EW  = LAG_W + K_W + 2;
  localparam logic [K_W-1:0] TOP = K_W'(csf_top_value(F));

  logic en;

  logic             pv;
  logic [LAG_W-1:0] plag;
  logic             plast, pflag, pgt;
  logic [F+1:0]     pnum;
  logic [2*F+1:0]   pa;
  logic [2*F:0]     pp, pq;
  logic [SBW-1:0]   sb_mul, sb_sq, sb_div;

  logic             mv;
  logic [4*F:0]     mprod;
  logic             sv;
  logic [2*F:0]     sy;

  logic             dv, dflag, dlast;
  logic [LAG_W-1:0] dlag;
  logic [K_W-1:0]   dk;

  logic [EW-1:0] buf_r [2];
  logic          wr_ptr_r, rd_ptr_r;
  logic [1:0]    cnt_r;
  logic          push, pop;

  // pipeline advances while the output buffer has room
  assign en        = (cnt_r != 2'd2);
  assign in_tready = en;

  csf_prep #(.F(F)) u_prep (
    .clk(clk), .rst_n(rst_n), .en(en),
    .valid_i(in_tvalid),
    .lag_i(in_tdata[15:0]),
    .mcorr_i(in_tdata[31:16]),
    .rcorr_i(in_tdata[47:32]),
    .last_i(in_tlast),
    .valid_o(pv), .lag_o(plag), .last_o(plast), .flag_o(pflag), .gt_o(pgt),
    .num_o(pnum), .a_o(pa), .p_o(pp), .q_o(pq)
  );

  assign sb_mul = {plag, plast, pflag, pgt, pnum, pa};

  csf_mul #(.F(F), .SBW(SBW)) u_mul (
    .clk(clk), .rst_n(rst_n), .en(en),
    .valid_i(pv), .p_i(pp), .q_i(pq), .sb_i(sb_mul),
    .valid_o(mv), .prod_o(mprod), .sb_o(sb_sq)
  );

  csf_sqrt #(.F(F), .SBW(SBW)) u_sqrt (
    .clk(clk), .rst_n(rst_n), .en(en),
    .valid_i(mv), .x_i(mprod), .sb_i(sb_sq),
    .valid_o(sv), .y_o(sy), .sb_o(sb_div)
  );

  csf_div #(.F(F)) u_div (
    .clk(clk), .rst_n(rst_n), .en(en),
    .valid_i(sv),
    .a_i(sb_div[2*F+1:0]),
    .y_i(sy),
    .num_i(sb_div[3*F+3:2*F+2]),
    .gt_i(sb_div[3*F+4]),
    .flag_i(sb_div[3*F+5]),
    .lag_i(sb_div[SBW-1:SBW-LAG_W]),
    .last_i(sb_div[3*F+6]),
    .valid_o(dv), .lag_o(dlag), .k_o(dk), .flag_o(dflag), .last_o(dlast)
  );

  // output buffer
  assign push = en && dv;
  assign pop  = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= {dlast, dflag, dk, dlag};
    end
  end

  assign out_tvalid   = (cnt_r != 2'd0);
  assign out_tdata    = buf_r[rd_ptr_r][LAG_W+K_W-1:0];
  assign out_tuser[0] = buf_r[rd_ptr_r][LAG_W+K_W];
  assign out_tlast    = buf_r[rd_ptr_r][LAG_W+K_W+1];

`ifndef NO_ASSERTIONS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("output buffer count out of range");

  a_pop_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> (cnt_r == $past(cnt_r) - 2'd1))
    else $error("output buffer did not drain on transfer");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2) |-> !in_tready)
    else $error("input taken while output buffer full");

  a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[LAG_W+K_W-1:LAG_W] <= TOP))
    else $error("coherent fraction above one");
`endif

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int FB = 15;
  localparam int LAT = 2 * FB + (2 * FB + 16) / 16 + 23;
  localparam int WDOG_LIMIT = 20000;
  localparam int N_RANDOM = 1100;

  typedef struct packed {
    logic [15:0] lag;
    logic [15:0] r;
    logic [15:0] rr;
    logic        last;
  } point_t;

  typedef struct packed {
    logic [15:0] lag;
    logic [15:0] k;
    logic        clamped;
    logic        last;
  } fraction_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic [0:0]  out_tuser;
  logic        out_tlast;

  point_t    pending_points[$];
  fraction_t expected_fractions[$];
  int        n_errors;
  bit        in_taken;
  bit        hold_active;
  bit        hold_done;
  int        hold_count;
  int        idle_cycles;
  int        cycle_no;

  coherent_scattering_fraction_top #(.FRAC_BITS(FB)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  // clock
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // saturate a correlation to +-one
  function automatic longint sat_corr(input logic [15:0] v, inout bit flag);
    longint x;
    longint one;
    one = longint'(1) << FB;
    x = longint'($signed(v));
    if (x > one) begin
      flag = 1;
      x = one;
    end else if (x < -one) begin
      flag = 1;
      x = -one;
    end
    return x;
  endfunction

  // floor square root of a wide product
  function automatic logic [63:0] isqrt_prod(input logic [63:0] p, input logic [63:0] q);
    logic [127:0] prod;
    logic [63:0]  y;
    logic [63:0]  t;
    prod = p * q;
    y = 0;
    for (int b = 2 * FB; b >= 0; b--) begin
      t = y | (64'd1 << b);
      if ({64'd0, t} * {64'd0, t} <= prod) y = t;
    end
    return y;
  endfunction

  // coherent scattering fraction of one curve point
  function automatic fraction_t calc_fraction(input point_t pt);
    fraction_t res;
    bit        flag;
    longint    r, s, one2;
    logic [63:0] top, a, p, q, den, num, lim, quo, rem;
    bit        over;
    flag = 0;
    top = (FB >= 16) ? 64'd65535 : (64'd1 << FB);
    one2 = longint'(1) << (2 * FB);
    r = sat_corr(pt.r, flag);
    s = sat_corr(pt.rr, flag);
    res.k = 0;
    if (r > s) begin
      a = one2 - r * s;
      p = one2 - r * r;
      q = one2 - s * s;
      den = a + isqrt_prod(p, q);
      num = r - s;
      lim = 2 * top + 1;
      if (den == 0) begin
        res.k = top[15:0];
        flag = 1;
      end else begin
        quo = num / den;
        rem = num % den;
        over = quo >= lim;
        for (int i = 0; i < 2 * FB + 1 && !over; i++) begin
          rem = rem << 1;
          quo = quo << 1;
          if (rem >= den) begin
            rem = rem - den;
            quo = quo | 64'd1;
          end
          if (quo >= lim) over = 1;
        end
        if (over) begin
          res.k = top[15:0];
          flag = 1;
        end else begin
          res.k = 16'((quo + 1) >> 1);
        end
      end
    end
    res.lag = pt.lag;
    res.clamped = flag;
    res.last = pt.last;
    return res;
  endfunction

  function automatic point_t mk_point(input int lag, input int r, input int rr, input bit last);
    point_t pt;
    pt.lag = lag[15:0];
    pt.r = r[15:0];
    pt.rr = rr[15:0];
    pt.last = last;
    return pt;
  endfunction

  // idling is off in a stretch of cycles in the middle of the run
  function automatic bit idle_now();
    if (cycle_no >= 700 && cycle_no < 1000) return 0;
    return $urandom_range(99) < 25;
  endfunction

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_taken) void'(pending_points.pop_front());
      if (in_tvalid && !in_taken) begin
        in_tvalid <= 1'b1;
      end else if (pending_points.size() > 0 && !idle_now()) begin
        in_tvalid <= 1'b1;
        in_tdata  <= {pending_points[0].rr, pending_points[0].r, pending_points[0].lag};
        in_tlast  <= pending_points[0].last;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver ready, with one long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_active) begin
      out_tready <= 1'b0;
      if (hold_count >= 300) begin
        hold_active <= 1'b0;
        hold_done <= 1'b1;
      end
      hold_count <= hold_count + 1;
    end else if (!hold_done && cycle_no == 200) begin
      hold_active <= 1'b1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= !idle_now();
    end
  end

  // monitor and input-side prediction
  always @(posedge clk) begin
    fraction_t got;
    fraction_t exp_f;
    in_taken <= rst_n && in_tvalid && in_tready;
    if (rst_n) begin
      cycle_no <= cycle_no + 1;
      idle_cycles <= ((in_tvalid && in_tready) || (out_tvalid && out_tready)) ?
                     0 : idle_cycles + 1;
      if (in_tvalid && in_tready) begin
        expected_fractions = {expected_fractions, calc_fraction(
          mk_point(in_tdata[15:0], in_tdata[31:16], in_tdata[47:32], in_tlast))};
      end
      if (out_tvalid && out_tready) begin
        got.lag = out_tdata[15:0];
        got.k = out_tdata[31:16];
        got.clamped = out_tuser[0];
        got.last = out_tlast;
        if (expected_fractions.size() == 0) begin
          $display("%0t: unexpected transfer, actual %h", $time, got);
          n_errors++;
        end else begin
          exp_f = expected_fractions.pop_front();
          if (got.lag !== exp_f.lag)
            $display("%0t: lag expected %h actual %h", $time, exp_f.lag, got.lag);
          if (got.k !== exp_f.k)
            $display("%0t: fraction expected %h actual %h", $time, exp_f.k, got.k);
          if (got.clamped !== exp_f.clamped)
            $display("%0t: clamped expected %b actual %b", $time, exp_f.clamped, got.clamped);
          if (got.last !== exp_f.last)
            $display("%0t: last expected %b actual %b", $time, exp_f.last, got.last);
          if (got !== exp_f) n_errors++;
        end
      end
    end
  end

  // stimulus and end of run
  initial begin
    int r, rr, sel;
    n_errors = 0;
    cycle_no = 0;
    idle_cycles = 0;
    in_taken = 0;
    hold_active = 0;
    hold_done = 0;
    hold_count = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    out_tready = 1'b0;

    // directed points: extremes, equal inputs, near one
    pending_points = {pending_points, mk_point(0, 32767, -32768, 0)};
    pending_points = {pending_points, mk_point(65535, -32768, 32767, 1)};
    pending_points = {pending_points, mk_point(1, 0, 0, 0)};
    pending_points = {pending_points, mk_point(2, 32767, 32767, 0)};
    pending_points = {pending_points, mk_point(3, -32768, -32768, 0)};
    pending_points = {pending_points, mk_point(4, 32767, 32766, 0)};
    pending_points = {pending_points, mk_point(5, 32767, 0, 0)};
    pending_points = {pending_points, mk_point(6, 0, -32768, 0)};
    pending_points = {pending_points, mk_point(7, 1, 0, 0)};
    pending_points = {pending_points, mk_point(8, 0, -1, 0)};
    pending_points = {pending_points, mk_point(9, 16384, 8192, 0)};
    pending_points = {pending_points, mk_point(10, -8192, -16384, 0)};
    pending_points = {pending_points, mk_point(11, 100, 200, 0)};
    pending_points = {pending_points, mk_point(12, -32767, -32768, 0)};
    pending_points = {pending_points, mk_point(16'haaaa, 16'h5555, 16'haaaa, 1)};
    pending_points = {pending_points, mk_point(16'h5555, 16'h2aaa, 16'hd555, 0)};

    for (int i = 0; i < N_RANDOM; i++) begin
      sel = $urandom_range(9);
      r = $urandom_range(65535);
      rr = $urandom_range(65535);
      // mostly r above rR so the divider path is exercised
      if (sel < 7 && $signed(r[15:0]) <= $signed(rr[15:0])) begin
        int tmp;
        tmp = r;
        r = rr;
        rr = tmp;
      end
      if (sel == 8) rr = r;
      if (sel == 9) r = 32767 - $urandom_range(64);
      pending_points = {pending_points,
                        mk_point($urandom_range(65535), r, rr, $urandom_range(15) == 0)};
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (pending_points.size() > 0 || expected_fractions.size() > 0) begin
      @(posedge clk);
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
    repeat (2 * LAT) @(posedge clk);
    if (n_errors == 0 && expected_fractions.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/csf_pkg.sv
design/csf_prep.sv
design/csf_mul.sv
design/csf_sqrt.sv
design/csf_div.sv
design/coherent_scattering_fraction_top.sv
test/testbench.sv
